>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property at each rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> hdl/ilir_pkg.sv
package ilir_pkg;

    // Request kinds
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_READ   = 3'd2;
    localparam logic [2:0] MODE_WRITE  = 3'd3;
    localparam logic [2:0] MODE_REMOVE = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam int unsigned IN_BITS  = 40;
    localparam int unsigned OUT_BITS = 40;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [3:0]  index;
        logic        [2:0]  mode;
    } t_req;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [4:0]  item_count;
        logic signed [31:0] read_value;
    } t_result;

endpackage

>>> hdl/indexed_list_insert_remove.sv
// Channel | Dir | Beat fields (lowest bit up)
// --------+-----+---------------------------------------------------------------
// s_axis  | in  | mode[2:0], index[6:3], value[38:7], zero pad [39]
// m_axis  | out | read_value[31:0], item_count[36:32], status[38:37], zero pad [39]
//
// One request is worked at a time. Append, overwrite, insert at the end, last-entry
// remove, bad requests and unknown modes go straight to the result; read passes a read
// state; insert and remove shift the list tail, then insert writes its value.
// Single memory write port: one entry moves per cycle, read the cycle before its write.
// Reset (i_rst_n low, synchronous) clears the count; the list memory is not cleared.
// A stalled result sits in the output register while the next request is taken.
module indexed_list_insert_remove #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // mode[2:0], index[6:3], value[38:7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_value[31:0], item_count[36:32], status[38:37]
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    ilir_pkg::t_req    req;
    ilir_pkg::t_result res;
    ilir_pkg::t_result out_res;
    logic              res_valid;
    logic              res_ready;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [31:0]       mem_rdata;

    // Unpack the request beat; the pad bit is dropped
    assign req = ilir_pkg::t_req'(s_axis_tdata[38:0]);

    // Sequencer: checks the request against the count, runs the entry shifts
    ilir_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // List storage: one write and one registered read per cycle
    ilir_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register parts the result side from the sequencer
    ilir_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res};

endmodule

>>> hdl/ilir_mem.sv
module ilir_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ilir_ctrl.sv
module ilir_ctrl #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned AW       = 4,
    parameter int unsigned CW       = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  ilir_pkg::t_req    i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output ilir_pkg::t_result o_res,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [31:0]       o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [31:0]       i_mem_rdata
);

    localparam int unsigned   IW       = (CW > 4) ? CW : 4;
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_TAIL,
        S_FIN,
        S_RD,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_src;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_wa;
    logic [AW-1:0] r_idx;
    logic          r_up;
    logic          r_ins;
    logic          r_pend;
    logic [31:0]   r_val;
    logic [31:0]   r_rdval;
    logic [1:0]    r_status;

    t_state        n_state;
    logic [1:0]    n_status;
    logic [CW-1:0] n_count;

    logic [IW-1:0] idx_w;
    logic [IW-1:0] cnt_w;
    logic [IW-1:0] cnt_m1;
    logic          full;
    logic          accept;
    logic          quick_wr;

    assign idx_w  = IW'(i_req.index);
    assign cnt_w  = IW'(r_count);
    assign cnt_m1 = cnt_w - 1'b1;
    assign full   = (r_count == FULL_CNT);
    assign accept = (r_state == S_IDLE) && i_req_valid;

    // Writes that finish in the accept cycle: append, overwrite, insert at the end
    always_comb begin
        quick_wr = 1'b0;
        case (i_req.mode)
            ilir_pkg::MODE_APPEND: quick_wr = !full;
            ilir_pkg::MODE_INSERT: quick_wr = !full && (idx_w == cnt_w);
            ilir_pkg::MODE_WRITE:  quick_wr = (idx_w < cnt_w);
            default:               quick_wr = 1'b0;
        endcase
    end

    // Outcome of a request: status, next count and where the sequencer goes
    always_comb begin
        n_state  = S_DONE;
        n_status = ilir_pkg::ST_OK;
        n_count  = r_count;
        case (i_req.mode)
            ilir_pkg::MODE_APPEND: begin
                if (full) begin
                    n_status = ilir_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ilir_pkg::MODE_INSERT: begin
                if (full) begin
                    n_status = ilir_pkg::ST_FULL;
                end else if (idx_w > cnt_w) begin
                    n_status = ilir_pkg::ST_BAD_INDEX;
                end else if (idx_w == cnt_w) begin
                    n_count = r_count + 1'b1;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            ilir_pkg::MODE_READ: begin
                if (idx_w >= cnt_w) begin
                    n_status = ilir_pkg::ST_BAD_INDEX;
                end else begin
                    n_state = S_RD;
                end
            end
            ilir_pkg::MODE_WRITE: begin
                if (idx_w >= cnt_w) begin
                    n_status = ilir_pkg::ST_BAD_INDEX;
                end
            end
            ilir_pkg::MODE_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ilir_pkg::ST_EMPTY;
                end else if (idx_w >= cnt_w) begin
                    n_status = ilir_pkg::ST_BAD_INDEX;
                end else if (idx_w == cnt_m1) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    // Memory port: a shift write lands in the cycle after its read
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wa;
        o_mem_wdata = i_mem_rdata;
        if (r_pend) begin
            o_mem_we = 1'b1;
        end else if (r_state == S_FIN) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_idx;
            o_mem_wdata = r_val;
        end else if (accept && quick_wr) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = (i_req.mode == ilir_pkg::MODE_APPEND) ? AW'(r_count)
                                                                : AW'(i_req.index);
            o_mem_wdata = i_req.value;
        end
        o_mem_raddr = (r_state == S_SHIFT) ? r_src : AW'(i_req.index);
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, item_count: 5'(r_count), read_value: r_rdval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_rdval  <= '0;
                        r_status <= n_status;
                        r_val    <= i_req.value;
                        r_idx    <= AW'(i_req.index);
                        r_count  <= n_count;
                        r_state  <= n_state;
                        // Insert walks down from the tail, remove walks up from the hole
                        r_ins    <= (i_req.mode == ilir_pkg::MODE_INSERT);
                        r_up     <= (i_req.mode != ilir_pkg::MODE_INSERT);
                        if (i_req.mode == ilir_pkg::MODE_INSERT) begin
                            r_src <= AW'(r_count - 1'b1);
                            r_end <= AW'(i_req.index);
                        end else begin
                            r_src <= AW'(i_req.index) + 1'b1;
                            r_end <= AW'(r_count - 1'b1);
                        end
                    end
                end
                S_SHIFT: begin
                    r_pend <= 1'b1;
                    r_wa   <= r_up ? (r_src - 1'b1) : (r_src + 1'b1);
                    if (r_src == r_end) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_src <= r_up ? (r_src + 1'b1) : (r_src - 1'b1);
                    end
                end
                S_TAIL: begin
                    r_pend <= 1'b0;
                    if (r_ins) begin
                        r_state <= S_FIN;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_FIN: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_RD: begin
                    r_rdval <= i_mem_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/ilir_obuf.sv
module ilir_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ilir_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output ilir_pkg::t_result o_data
);

    logic              r_valid;
    ilir_pkg::t_result r_data;
    logic              load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload holds while the beat is stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/ilir_chk.sv
`include "assert_macros.svh"

module ilir_chk #(
    parameter int unsigned CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    logic [1:0]  st;
    logic [4:0]  cnt;
    logic [31:0] rdv;
    logic        out_stall;

    assign st        = m_axis_tdata[38:37];
    assign cnt       = m_axis_tdata[36:32];
    assign rdv       = m_axis_tdata[31:0];
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // No result beat right after reset
    `ASSERT_ALWAYS(a_no_out_after_rst, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // A stalled result beat holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

    // Only a good read carries data; failed requests report zero
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && st != ilir_pkg::ST_OK |-> rdv == 32'd0)

    // The count never passes the capacity
    `ASSERT_CLK(a_cnt_cap, i_clk, i_rst_n, m_axis_tvalid |-> cnt <= CAPACITY)

    // A full-list status only comes with a full count
    `ASSERT_CLK(a_full_cnt, i_clk, i_rst_n, m_axis_tvalid && st == ilir_pkg::ST_FULL |-> cnt == CAPACITY)

endmodule

bind indexed_list_insert_remove ilir_chk #(.CAPACITY(CAPACITY)) u_chk (.*);
